@@ hw/rtl/crc_generate_and_check_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef CRC_GENERATE_AND_CHECK_UNIT_ASSERT_SVH
`define CRC_GENERATE_AND_CHECK_UNIT_ASSERT_SVH

// checked only outside reset
`define CRCGC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CRCGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/crcgc_pkg.sv @@
// types and constants shared by the crc unit
package crcgc_pkg;

  localparam int MAX_DEGREE = 32;
  localparam int REM_W      = (MAX_DEGREE < 32) ? MAX_DEGREE : 32;
  localparam int DEG_W      = $clog2(REM_W + 1);
  localparam int CFG_W      = 32;
  localparam int DEG_CFG_W  = 6;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [0:0] {
    REG_POLY_LOW = 1'b0,
    REG_DEGREE   = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    FUNC_GEN   = 1'b0,
    FUNC_CHECK = 1'b1
  } func_t;

  typedef enum logic [0:0] {
    KIND_CODE    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  // one classified beat handed from front to back
  typedef struct packed {
    func_t            func;
    logic             data_bit;
    logic             last;
    logic             err;
    logic [REM_W-1:0] rem;   // remainder, msb of the check field at the top
    logic [DEG_W-1:0] n;     // effective degree
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  code_bit;
    logic  error;
    logic  end_of_run;
  } res_t;

endpackage

@@ hw/rtl/crcgc_front.sv @@
// front: config registers, remainder update and beat classification
module crcgc_front import crcgc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             accept,
  input  logic             func,
  input  logic             data_bit,
  input  logic             last,
  output logic             cmd_push,
  output cmd_t             cmd
);

  logic [CFG_W-1:0]     poly_low;
  logic [DEG_CFG_W-1:0] degree;
  logic [REM_W-1:0]     remainder;

  logic [DEG_W-1:0] n;
  logic [REM_W-1:0] mask, top_mask, r, g, nr;
  logic             top, fb;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_low <= CFG_W'(3);
      degree   <= DEG_CFG_W'(4);
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_POLY_LOW: poly_low <= cfg_data;
        REG_DEGREE:   degree   <= cfg_data[DEG_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // degree clamped to 1..REM_W
  always_comb begin
    if (degree == '0) n = DEG_W'(1);
    else if (degree > DEG_CFG_W'(REM_W)) n = DEG_W'(REM_W);
    else n = degree[DEG_W-1:0];
  end

  assign mask     = ~({REM_W{1'b1}} << n);
  assign top_mask = mask ^ (mask >> 1);
  assign r        = remainder & mask;
  assign g        = poly_low[REM_W-1:0] & mask;
  assign top      = |(r & top_mask);
  assign fb       = top ^ data_bit;

  always_comb begin
    if (func_t'(func) == FUNC_GEN) begin
      nr = ((r << 1) & mask) ^ ({REM_W{fb}} & g);
    end else begin
      nr = (((r << 1) | REM_W'(data_bit)) & mask) ^ ({REM_W{top}} & g);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (accept) begin
      remainder <= last ? '0 : nr;
    end
  end

  // check beats other than the last give nothing to the back
  assign cmd_push     = accept && ((func_t'(func) == FUNC_GEN) || last);
  assign cmd.func     = func_t'(func);
  assign cmd.data_bit = data_bit;
  assign cmd.last     = last;
  assign cmd.err      = |nr;
  assign cmd.rem      = nr << (DEG_W'(REM_W) - n);
  assign cmd.n        = n;

endmodule

@@ hw/rtl/crcgc_queue.sv @@
// short command queue between front and back
module crcgc_queue import crcgc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/crcgc_back.sv @@
// back: result register and check-bit serialiser
module crcgc_back import crcgc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  cmd_t q_head,
  output logic q_pop,
  output logic out_valid,
  output res_t res,
  input  logic pop
);

  logic [DEG_W-1:0] ser_cnt;
  logic [REM_W-1:0] ser_sh;
  logic             adv;

  assign adv   = !out_valid || pop;
  assign q_pop = adv && (ser_cnt == '0) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ser_cnt   <= '0;
    end else if (adv) begin
      if (ser_cnt != '0) begin
        out_valid <= 1'b1;
        ser_cnt   <= ser_cnt - DEG_W'(1);
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        if (q_head.func == FUNC_GEN && q_head.last) ser_cnt <= q_head.n;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ser_cnt != '0) begin
        res.kind       <= KIND_CODE;
        res.code_bit   <= ser_sh[REM_W-1];
        res.error      <= 1'b0;
        res.end_of_run <= (ser_cnt == DEG_W'(1));
        ser_sh         <= ser_sh << 1;
      end else if (!q_empty) begin
        if (q_head.func == FUNC_CHECK) begin
          res.kind       <= KIND_VERDICT;
          res.code_bit   <= 1'b0;
          res.error      <= q_head.err;
          res.end_of_run <= 1'b1;
        end else begin
          res.kind       <= KIND_CODE;
          res.code_bit   <= q_head.data_bit;
          res.error      <= 1'b0;
          res.end_of_run <= !q_head.last;
        end
        ser_sh <= q_head.rem;
      end
    end
  end

endmodule

@@ hw/rtl/crc_generate_and_check_unit.sv @@
// top level of the bit-serial crc generate and check unit
//
//   channel   direction  handshake             beat
//   input     in         push / full           func, data_bit, last
//   result    out        empty / pop           kind, code_bit, error, end_of_run
//   config    in         cfg_wr_en             cfg_index, cfg_data
//
// one input bit is taken per cycle while full is low; the remainder shift and xor in the front
// are combinational, and the remainder register updates on each accepted bit
// results leave at one per cycle while pop is high; a generate last bit yields clamped degree+1
// results, so the back's serialiser sets the pace while the queue fills
// the back registers each result from the command at the queue head into its result register
// rst is synchronous; after it the queue and result register are empty
// full rises when the four-entry queue is full; pop low holds the result
module crc_generate_and_check_unit import crcgc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // input side
  input  logic             push,
  output logic             full,
  input  logic             func,
  input  logic             data_bit,
  input  logic             last,
  // result side
  output logic             empty,
  input  logic             pop,
  output logic             kind,
  output logic             code_bit,
  output logic             error,
  output logic             end_of_run
);

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  logic q_empty, q_pop;
  cmd_t q_head;
  logic out_valid;
  res_t res;

  // input beat taken when the queue has room
  assign accept = push && !full;

  crcgc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .func      (func),
    .data_bit  (data_bit),
    .last      (last),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  // decouples the front, one bit a cycle unless held by full, from the serialising back
  crcgc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd),
    .full      (full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  crcgc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .res       (res),
    .pop       (pop)
  );

  // result beat straight from the output register
  assign empty      = !out_valid;
  assign kind       = res.kind;
  assign code_bit   = res.code_bit;
  assign error      = res.error;
  assign end_of_run = res.end_of_run;

endmodule

@@ hw/rtl/crcgc_checker.sv @@
// port-level checker for the crc unit, bound to the top level
`include "crc_generate_and_check_unit_assert.svh"

module crcgc_checker import crcgc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cfg_wr_en,
  input logic [0:0]       cfg_index,
  input logic [CFG_W-1:0] cfg_data,
  input logic             push,
  input logic             full,
  input logic             func,
  input logic             data_bit,
  input logic             last,
  input logic             empty,
  input logic             pop,
  input logic             kind,
  input logic             code_bit,
  input logic             error,
  input logic             end_of_run
);

  // reset leaves nothing pending and room for input
  `CRCGC_ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) |-> (empty && !full), "not clear after reset")

  // a verdict carries no code bit and always ends its run
  `CRCGC_ASSERT(a_verdict_form, clk, rst, (!empty && kind) |-> (!code_bit && end_of_run), "bad verdict")

  // a codeword bit never flags an error
  `CRCGC_ASSERT(a_code_no_err, clk, rst, (!empty && !kind) |-> !error, "error on codeword bit")

  // a waiting result holds until taken
  `CRCGC_ASSERT(a_result_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable({kind, code_bit, error, end_of_run})), "result changed while stalled")

endmodule

bind crc_generate_and_check_unit crcgc_checker u_crcgc_checker (.*);

@@ verif/crc_generate_and_check_unit_tb.sv @@
// self-checking testbench for the bit-serial crc generate and check unit
module crc_generate_and_check_unit_tb;
  import crcgc_pkg::*;

  localparam int RANDOM_ITEMS   = 280;
  // front stage, four-entry queue, serialiser and result register, with margin
  localparam int SETTLE_CYCLES  = 16;
  // longest quiet stretch: settle pause, longest pop stall, longest push gap
  localparam int WATCHDOG_LIMIT = 2000;

  // one row of the directed plan: either a register write or one input beat
  typedef struct {
    bit               is_write;
    reg_idx_t         idx;
    logic [CFG_W-1:0] val;
    func_t            f;
    logic             d;
    logic             l;
    bit               typed;   // first result given by hand below
    res_t             first;
  } plan_row_t;

  localparam res_t NO_RES = '0;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [0:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             push      = 1'b0;
  logic             full;
  logic             func      = 1'b0;
  logic             data_bit  = 1'b0;
  logic             last      = 1'b0;
  logic             empty;
  logic             pop       = 1'b0;
  logic             kind;
  logic             code_bit;
  logic             error;
  logic             end_of_run;

  crc_generate_and_check_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the configuration and of the running remainder
  logic [CFG_W-1:0]     poly_shadow   = 32'd3;
  logic [DEG_CFG_W-1:0] degree_shadow = 6'd4;
  logic [REM_W-1:0]     crc_rem       = '0;

  res_t expected_beats[$];   // results still owed by the block, oldest first
  logic codeword_bits[$];    // codeword bits produced in generate mode
  res_t want_beat;
  int   bits_sent      = 0;
  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  int   burst_left     = 0;
  bit   settled        = 1'b1;

  // directed plan: field extremes, both modes, mode switches, degree clamping and
  // a degree change in the middle of an open check run
  plan_row_t directed_plan [35] = '{
    // straight after reset: degree 4, poly 0x3
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b1, 1'b0, 1'b1,
      res_t'{KIND_CODE, 1'b1, 1'b0, 1'b1}},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b0, 1'b0, 1'b1,
      res_t'{KIND_CODE, 1'b0, 1'b0, 1'b1}},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b1, 1'b1, 1'b1,
      res_t'{KIND_CODE, 1'b1, 1'b0, 1'b0}},
    // single-bit check runs from a cleared remainder
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b0, 1'b1, 1'b1,
      res_t'{KIND_VERDICT, 1'b0, 1'b0, 1'b1}},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b1, 1'b1, 1'b1,
      res_t'{KIND_VERDICT, 1'b0, 1'b1, 1'b1}},
    // mode switched bit by bit, one run closing on a generate bit, the next on a check bit
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b0, 1'b1, 1'b0, NO_RES},
    // degree zero behaves as degree one
    '{1'b1, REG_POLY_LOW, 32'hFFFF_FFFF, FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_DEGREE,   32'd0,         FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b1, 1'b1, 1'b1,
      res_t'{KIND_CODE, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b1, 1'b1, 1'b0, NO_RES},
    // all-ones degree clamps to the widest remainder, run left open at the end
    '{1'b1, REG_POLY_LOW, 32'h04C1_1DB7, FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_DEGREE,   32'd63,        FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b1, 1'b1, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b1, 1'b0, 1'b0, NO_RES},
    // just above the maximum, rewritten while that run is still open
    '{1'b1, REG_DEGREE,   32'd33,        FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b0, 1'b1, 1'b0, NO_RES},
    // smallest and largest legal degree with an empty polynomial
    '{1'b1, REG_POLY_LOW, 32'h0,         FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_DEGREE,   32'd1,         FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b1, 1'b1, 1'b0, NO_RES},
    '{1'b1, REG_DEGREE,   32'd32,        FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_GEN,   1'b0, 1'b1, 1'b1,
      res_t'{KIND_CODE, 1'b0, 1'b0, 1'b0}},
    // degree shrunk mid-run: the open remainder gets masked down
    '{1'b1, REG_POLY_LOW, 32'h7,         FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_DEGREE,   32'd8,         FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b1, REG_DEGREE,   32'd3,         FUNC_GEN, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, REG_POLY_LOW, 32'h0, FUNC_CHECK, 1'b1, 1'b1, 1'b0, NO_RES}
  };

  // one step of modulo-2 long division; queues the results the bit causes
  task automatic crc_divide_bit(input func_t f, input logic d, input logic l);
    int               n;
    logic [REM_W-1:0] m;
    logic [REM_W-1:0] g;
    logic [REM_W-1:0] r;
    logic             top;
    logic             fb;
    n = int'(degree_shadow);
    if (n < 1) n = 1;
    if (n > REM_W) n = REM_W;
    m   = {REM_W{1'b1}} >> (REM_W - n);
    g   = poly_shadow[REM_W-1:0] & m;
    r   = crc_rem & m;          // a degree change masks the open remainder
    top = r[n-1];
    if (f == FUNC_GEN) begin
      // remainder of message times x^n: feed the incoming bit into the top
      fb = top ^ d;
      r  = (r << 1) & m;
      if (fb) r ^= g;
      expected_beats.push_back(res_t'{KIND_CODE, d, 1'b0, !l});
      codeword_bits.push_back(d);
      if (l) begin
        // check field goes out msb first
        for (int i = n - 1; i >= 0; i--) begin
          expected_beats.push_back(res_t'{KIND_CODE, r[i], 1'b0, i == 0});
          codeword_bits.push_back(r[i]);
        end
      end
    end else begin
      // plain division of the codeword as it arrives
      r = ((r << 1) | REM_W'(d)) & m;
      if (top) r ^= g;
      if (l) expected_beats.push_back(res_t'{KIND_VERDICT, 1'b0, r != '0, 1'b1});
    end
    crc_rem = l ? '0 : r;
  endtask

  // offer one beat; the sender runs in bursts with random gaps between them
  task automatic send_bit(input func_t f, input logic d, input logic l,
                          input bit typed = 1'b0, input res_t first = '0);
    int slot;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk) push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    push     <= 1'b1;
    func     <= f;
    data_bit <= d;
    last     <= l;
    do @(posedge clk); while (full);
    burst_left--;
    bits_sent++;
    settled = 1'b0;
    slot    = expected_beats.size();
    crc_divide_bit(f, d, l);
    // hand-typed first result takes the place of the predicted one
    if (typed) expected_beats[slot] = first;
  endtask

  // stop offering, collect every owed result, then let the pipe run dry
  task automatic settle_block;
    if (!settled) begin
      @(negedge clk) push <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      settled = 1'b1;
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    settle_block();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_POLY_LOW) poly_shadow = val;
    else degree_shadow = val[DEG_CFG_W-1:0];
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  task automatic flag_field(input string field, input logic want, input logic got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // receiver: pop follows a rotating pattern, reloaded now and then, sometimes
  // with all ones for a stretch with no stalls; bit 0 always set bounds a stall
  logic [31:0] stall_pattern = '1;
  int          pattern_age   = 0;

  always @(negedge clk) begin
    if (pattern_age == 0) begin
      stall_pattern = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'd1);
      pattern_age   = $urandom_range(20, 80);
    end
    pattern_age--;
    pop <= stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
  end

  // result monitor: every accepted beat is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no beat, got kind %0d code_bit %0d error %0d end_of_run %0d",
                 $time, kind, code_bit, error, end_of_run);
      end else begin
        want_beat = expected_beats.pop_front();
        flag_field("kind",       want_beat.kind,       kind);
        flag_field("code_bit",   want_beat.code_bit,   code_bit);
        flag_field("error",      want_beat.error,      error);
        flag_field("end_of_run", want_beat.end_of_run, end_of_run);
      end
    end
  end

  // watchdog: too long without any beat or register write means a hang
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_wr_en) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, expected_beats.size());
      $display("** crc_generate_and_check_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    int   base;
    int   sel;
    int   len;
    int   pos;
    int   tail;
    logic frame[$];

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed_plan[row]) begin
      if (directed_plan[row].is_write)
        write_reg(directed_plan[row].idx, directed_plan[row].val);
      else
        send_bit(directed_plan[row].f, directed_plan[row].d, directed_plan[row].l,
                 directed_plan[row].typed, directed_plan[row].first);
    end

    base = bits_sent;
    while (bits_sent - base < RANDOM_ITEMS) begin
      // new setting for most phases: mostly short degrees, a few at the limits
      if ($urandom_range(0, 9) < 7) begin
        sel = $urandom_range(0, 7);
        if ($urandom_range(0, 4) != 0)
          write_reg(REG_POLY_LOW, (sel == 0) ? 32'h0 :
                                  (sel == 1) ? 32'hFFFF_FFFF : 32'($urandom));
        sel = $urandom_range(0, 19);
        if ($urandom_range(0, 4) != 0)
          write_reg(REG_DEGREE, (sel < 14)  ? $urandom_range(1, 8) :
                                (sel == 14) ? 32'd0 :
                                (sel == 15) ? 32'd32 :
                                (sel == 16) ? $urandom_range(33, 63) :
                                              $urandom_range(9, 31));
      end

      repeat ($urandom_range(1, 4)) begin
        sel = $urandom_range(0, 19);
        len = $urandom_range(1, 10);
        if (sel < 14) begin
          // well-formed: generate a codeword, then check it, sometimes corrupted
          codeword_bits.delete();
          for (int i = 0; i < len; i++)
            send_bit(FUNC_GEN, 1'($urandom), i == len - 1);
          frame = codeword_bits;
          if ($urandom_range(0, 2) == 0) begin
            pos        = $urandom_range(0, frame.size() - 1);
            frame[pos] = !frame[pos];
          end
          foreach (frame[i])
            send_bit(FUNC_CHECK, frame[i], i == frame.size() - 1);
        end else if (sel < 17) begin
          // noise: any mode, any bit, the odd closing bit
          repeat (len)
            send_bit(func_t'(1'($urandom)), 1'($urandom), $urandom_range(0, 3) == 0);
        end else begin
          // broken: message bits then a check tail closing the run
          repeat (len) send_bit(FUNC_GEN, 1'($urandom), 1'b0);
          tail = $urandom_range(1, 4);
          for (int i = 0; i < tail; i++)
            send_bit(FUNC_CHECK, 1'($urandom), i == tail - 1);
        end
      end

      // leave a run open now and then so the next setting lands mid-run
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          send_bit(func_t'(1'($urandom)), 1'($urandom), 1'b0);
    end

    settle_block();
    if (mismatch_count == 0)
      $display("** crc_generate_and_check_unit: PASSED **");
    else
      $display("** crc_generate_and_check_unit: FAILED **");
    $finish;
  end

endmodule

@@ crc_generate_and_check_unit.f @@
+incdir+hw/rtl
hw/rtl/crcgc_pkg.sv
hw/rtl/crcgc_front.sv
hw/rtl/crcgc_queue.sv
hw/rtl/crcgc_back.sv
hw/rtl/crc_generate_and_check_unit.sv
hw/rtl/crcgc_checker.sv
verif/crc_generate_and_check_unit_tb.sv
